@@ hw/rtl/segment_page_map_translator_top_defines.svh @@
// Assertion macros for the segment/page map translator.
// Used by segment_page_map_translator_top; expects clk and arst_n in scope.
`ifndef SEGMENT_PAGE_MAP_TRANSLATOR_TOP_DEFINES_SVH
`define SEGMENT_PAGE_MAP_TRANSLATOR_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define SPMT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle
`define SPMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition must never hold
`define SPMT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ hw/rtl/spmt_pkg.sv @@
// Shared types and constants for the segment/page map translator.
// No dependencies; imported by spmt_ctrl, spmt_datapath and the top level.
package spmt_pkg;

	// Default geometry
	localparam int ADDRESS_BITS_DEF     = 24;
	localparam int PAGE_OFFSET_BITS_DEF = 11;
	localparam int PMEG_OFFSET_BITS_DEF = 4;
	localparam int CONTEXTS_DEF         = 8;
	localparam int PMEGS_DEF            = 256;

	// Entry flag positions
	localparam int SE_VALID_BIT = 15;
	localparam int PE_VALID_BIT = 31;
	localparam int PE_WRITE_BIT = 30;
	localparam int PE_SUPER_BIT = 29;
	localparam int PE_REF_BIT   = 25;
	localparam int PE_MOD_BIT   = 24;

	typedef enum logic [2:0] {
		ACT_TRANSLATE = 3'd0,
		ACT_SEG_RD    = 3'd1,
		ACT_SEG_WR    = 3'd2,
		ACT_PG_RD     = 3'd3,
		ACT_PG_WR     = 3'd4
	} spmt_action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_PRIV    = 2'd2,
		STAT_PROT    = 2'd3
	} spmt_status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SEG,
		S_DONE
	} spmt_state_t;

	// Controller to datapath
	typedef struct packed {
		logic clearing; // clearing pass: zero one entry of each map
		logic capture;  // request transfer: latch, access maps
		logic lookup;   // read page map for a translate
		logic finish;   // load response, write back page entry
	} spmt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;    // final entry of the clearing pass
		logic req_translate; // offered request is a translate
	} spmt_stat_t;

endpackage

@@ hw/rtl/spmt_ctrl.sv @@
// Sequencing state machine of the translator: clearing pass, request
// transfer, page lookup and response hand-off. Depends on spmt_pkg.
module spmt_ctrl
	import spmt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output spmt_cmd_t  cmd,
	input  spmt_stat_t stat
);

	spmt_state_t state_q, state_d;
	logic        rsp_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clearing = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = stat.req_translate ? S_SEG : S_DONE;
				end
			end
			S_SEG: begin
				cmd.lookup = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				// response register free or emptying this cycle
				if (!rsp_valid_q || rsp_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ hw/rtl/spmt_datapath.sv @@
// Datapath of the translator: segment and page map memories, index forming,
// access checks and the response register. Depends on spmt_pkg.
module spmt_datapath
	import spmt_pkg::*;
#(
	parameter int ADDRESS_BITS     = ADDRESS_BITS_DEF,
	parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
	parameter int PMEG_OFFSET_BITS = PMEG_OFFSET_BITS_DEF,
	parameter int CONTEXTS         = CONTEXTS_DEF,
	parameter int PMEGS            = PMEGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  spmt_cmd_t   cmd,
	output spmt_stat_t  stat,
	input  logic [2:0]  action,
	input  logic [2:0]  context_id,
	input  logic [31:0] virt_address,
	input  logic [11:0] page_index,
	input  logic [31:0] write_data,
	input  logic        is_write,
	input  logic        supervisor,
	output logic [31:0] read_data,
	output logic [1:0]  status,
	output logic [31:0] range_first,
	output logic [31:0] range_last,
	output logic        allow_system,
	output logic        allow_user,
	output logic        allow_read,
	output logic        allow_write
);

	localparam int SegOffBits = PAGE_OFFSET_BITS + PMEG_OFFSET_BITS;
	localparam int SegBits    = ADDRESS_BITS - SegOffBits;
	localparam int SegDepth   = CONTEXTS << SegBits;
	localparam int SegIdxW    = $clog2(SegDepth);
	localparam int PageDepth  = PMEGS << PMEG_OFFSET_BITS;
	localparam int PageIdxW   = $clog2(PageDepth);
	localparam int ClrDepth   = (SegDepth > PageDepth) ? SegDepth : PageDepth;
	localparam int ClrW       = $clog2(ClrDepth);
	localparam logic [PageIdxW-1:0] PgMask = PageIdxW'(
		((PMEGS - 1) << PMEG_OFFSET_BITS) | ((1 << PMEG_OFFSET_BITS) - 1));
	localparam logic [31:0] PgOffMask  = 32'((64'd1 << PAGE_OFFSET_BITS) - 64'd1);
	localparam logic [31:0] SegOffMask = 32'((64'd1 << SegOffBits) - 64'd1);
	localparam logic [15:0] PmegMask   = 16'(PMEGS - 1);

	logic [15:0]         seg_mem [SegDepth];
	logic [31:0]         pg_mem  [PageDepth];

	logic [ClrW-1:0]     clr_q;
	spmt_action_t        action_q;
	logic [31:0]         addr_q;
	logic                is_write_q;
	logic                supervisor_q;
	logic [15:0]         seg_rd_q;
	logic [31:0]         pg_rd_q;

	logic [2:0]          ctx_m;
	logic [SegIdxW-1:0]  seg_idx_req;
	logic [PageIdxW-1:0] pg_idx_req;
	logic [PageIdxW-1:0] pg_idx_xl;
	logic [15:0]         pmeg;
	logic [31:0]         pe_new;
	logic                xl_ok;

	logic                seg_we;
	logic [SegIdxW-1:0]  seg_waddr;
	logic [15:0]         seg_wdata;
	logic                pg_we;
	logic                pg_re;
	logic [PageIdxW-1:0] pg_waddr;
	logic [PageIdxW-1:0] pg_raddr;
	logic [31:0]         pg_wdata;

	logic [31:0]         res_data;
	spmt_status_t        res_status;
	logic [31:0]         res_first;
	logic [31:0]         res_last;
	logic [3:0]          res_allow;

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign stat.clear_last    = (clr_q == ClrW'(ClrDepth - 1));
	assign stat.req_translate = (action == ACT_TRANSLATE);

	// Context wraps modulo the bank count (narrow value, few steps)
	always_comb begin
		ctx_m = context_id;
		for (int i = 0; i < 8; i++) begin
			if (32'(ctx_m) >= CONTEXTS) begin
				ctx_m = ctx_m - 3'(CONTEXTS);
			end
		end
	end

	assign seg_idx_req = SegIdxW'({{SegIdxW{1'b0}}, ctx_m,
		virt_address[SegOffBits +: SegBits]});

	// Direct page index, masked to the map
	assign pg_idx_req = PageIdxW'({{PageIdxW{1'b0}}, page_index}) & PgMask;

	// Page index of a translate: PMEG from segment entry, page within PMEG
	assign pmeg      = seg_rd_q & PmegMask;
	assign pg_idx_xl = PageIdxW'({pmeg, addr_q[PAGE_OFFSET_BITS +: PMEG_OFFSET_BITS]})
		& PgMask;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q     <= spmt_action_t'(action);
			addr_q       <= virt_address;
			is_write_q   <= is_write;
			supervisor_q <= supervisor;
		end
	end

	// Segment map port control
	always_comb begin
		if (cmd.clearing) begin
			seg_we    = (32'(clr_q) < SegDepth);
			seg_waddr = clr_q[SegIdxW-1:0];
			seg_wdata = '0;
		end else begin
			seg_we    = cmd.capture && (action == ACT_SEG_WR);
			seg_waddr = seg_idx_req;
			seg_wdata = write_data[15:0];
		end
	end

	// Segment map memory
	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[seg_waddr] <= seg_wdata;
		end
		if (cmd.capture) begin
			seg_rd_q <= seg_mem[seg_idx_req];
		end
	end

	// Page map port control
	always_comb begin
		pg_re    = cmd.capture || cmd.lookup;
		pg_raddr = cmd.lookup ? pg_idx_xl : pg_idx_req;
		priority if (cmd.clearing) begin
			pg_we    = (32'(clr_q) < PageDepth);
			pg_waddr = clr_q[PageIdxW-1:0];
			pg_wdata = '0;
		end else if (cmd.finish) begin
			pg_we    = (action_q == ACT_TRANSLATE) && xl_ok;
			pg_waddr = pg_idx_xl;
			pg_wdata = pe_new;
		end else begin
			pg_we    = cmd.capture && (action == ACT_PG_WR);
			pg_waddr = pg_idx_req;
			pg_wdata = write_data;
		end
	end

	// Page map memory
	always_ff @(posedge clk) begin
		if (pg_we) begin
			pg_mem[pg_waddr] <= pg_wdata;
		end
		if (pg_re) begin
			pg_rd_q <= pg_mem[pg_raddr];
		end
	end

	// Page entry with referenced, and modified on a write
	assign pe_new = pg_rd_q | (32'd1 << PE_REF_BIT)
		| (is_write_q ? (32'd1 << PE_MOD_BIT) : 32'd0);

	// Access checks and response fields
	always_comb begin
		res_data   = '0;
		res_status = STAT_OK;
		res_first  = '0;
		res_last   = '0;
		res_allow  = '0; // {system, user, read, write}
		xl_ok      = 1'b0;
		unique case (action_q)
			ACT_TRANSLATE: begin
				res_first = addr_q & ~PgOffMask;
				res_last  = addr_q | PgOffMask;
				priority if (!seg_rd_q[SE_VALID_BIT]) begin
					res_status = STAT_INVALID;
					res_first  = addr_q & ~SegOffMask;
					res_last   = addr_q | SegOffMask;
					res_allow  = 4'b1111;
				end else if (!pg_rd_q[PE_VALID_BIT]) begin
					res_status = STAT_INVALID;
					res_allow  = 4'b1111;
				end else if (pg_rd_q[PE_SUPER_BIT] && !supervisor_q) begin
					res_status = STAT_PRIV;
					res_allow  = 4'b0111;
				end else if (!pg_rd_q[PE_WRITE_BIT] && is_write_q) begin
					res_status = STAT_PROT;
					res_allow  = 4'b1101;
				end else begin
					xl_ok     = 1'b1;
					res_data  = pe_new;
					res_allow = {1'b1, !pe_new[PE_SUPER_BIT], 1'b1,
						pe_new[PE_WRITE_BIT] & pe_new[PE_MOD_BIT]};
				end
			end
			ACT_SEG_RD: res_data = {16'd0, seg_rd_q};
			ACT_PG_RD:  res_data = pg_rd_q;
			default:    res_data = '0;
		endcase
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			read_data    <= res_data;
			status       <= res_status;
			range_first  <= res_first;
			range_last   <= res_last;
			allow_system <= res_allow[3];
			allow_user   <= res_allow[2];
			allow_read   <= res_allow[1];
			allow_write  <= res_allow[0];
		end
	end

endmodule

@@ hw/rtl/segment_page_map_translator_top.sv @@
// Segment/page map translator, top level: controller plus datapath.
// Depends on spmt_pkg, spmt_ctrl, spmt_datapath and the assertion macro header.
//
// Two-level MMU with a context-banked segment map and a page map, both held
// in single-port-per-side synchronous memories. After reset the block runs a
// clearing pass over max(segment map depth, page map depth) entries (4096 at
// the default geometry) with req_ready low. A translate does a segment map
// read, a page map read, then check and page entry write-back; entry reads
// and writes access their map at request transfer. The next request is
// taken in the cycle after the response is loaded, and a loaded response
// waiting on rsp_ready holds back only the following item's final step.
// Status 0 ok, 1 invalid, 2 privilege violation, 3 write protection.
`include "segment_page_map_translator_top_defines.svh"

module segment_page_map_translator_top
	import spmt_pkg::*;
#(
	parameter int ADDRESS_BITS     = ADDRESS_BITS_DEF,
	parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
	parameter int PMEG_OFFSET_BITS = PMEG_OFFSET_BITS_DEF,
	parameter int CONTEXTS         = CONTEXTS_DEF,
	parameter int PMEGS            = PMEGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  action,
	input  logic [2:0]  context_id,
	input  logic [31:0] virt_address,
	input  logic [11:0] page_index,
	input  logic [31:0] write_data,
	input  logic        is_write,
	input  logic        supervisor,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [31:0] read_data,
	output logic [1:0]  status,
	output logic [31:0] range_first,
	output logic [31:0] range_last,
	output logic        allow_system,
	output logic        allow_user,
	output logic        allow_read,
	output logic        allow_write
);

	spmt_cmd_t  cmd;
	spmt_stat_t stat;

	// Sequencer
	spmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Maps, checks and response register
	spmt_datapath #(
		.ADDRESS_BITS     (ADDRESS_BITS),
		.PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
		.PMEG_OFFSET_BITS (PMEG_OFFSET_BITS),
		.CONTEXTS         (CONTEXTS),
		.PMEGS            (PMEGS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.context_id   (context_id),
		.virt_address (virt_address),
		.page_index   (page_index),
		.write_data   (write_data),
		.is_write     (is_write),
		.supervisor   (supervisor),
		.read_data    (read_data),
		.status       (status),
		.range_first  (range_first),
		.range_last   (range_last),
		.allow_system (allow_system),
		.allow_user   (allow_user),
		.allow_read   (allow_read),
		.allow_write  (allow_write)
	);

	// Checks on the sequencing
	`SPMT_ASSERT_IMPL(a_no_req_in_clear, cmd.clearing, !req_ready, "request taken while clearing")
	`SPMT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "back-to-back transfer")
	`SPMT_ASSERT_IMPL(a_rsp_from_finish, $rose(rsp_valid), $past(cmd.finish), "response without finish")
	`SPMT_ASSERT_NEVER(a_finish_capture, cmd.finish && cmd.capture, "finish during capture")

endmodule
